/* design/mgpl_pkg.sv */
// shared types, register indexes and constants of the master gain peak limiter
// no dependencies
`timescale 1ns / 1ps

package mgpl_pkg;

	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 16;

	localparam logic [CfgIndexW-1:0] REG_MASTER_GAIN     = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_LIMITER_ON      = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_LIMIT_THRESHOLD = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_ATTACK_COEF     = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_RELEASE_COEF    = 3'd4;

	localparam logic [15:0] MASTER_GAIN_RST     = 16'd16384;
	localparam logic        LIMITER_ON_RST      = 1'b1;
	localparam logic [14:0] LIMIT_THRESHOLD_RST = 15'd31130;
	localparam logic [15:0] ATTACK_COEF_RST     = 16'd66;
	localparam logic [15:0] RELEASE_COEF_RST    = 16'd3277;

	localparam logic [15:0] GAIN_MAX = 16'd32768;

	// gain rounding and q3.24 envelope range
	localparam logic signed [47:0] GAIN_ROUND = 48'sd8192;
	localparam logic signed [47:0] SAMPLE_MAX = 48'sd131071;
	localparam logic signed [47:0] SAMPLE_MIN = -48'sd131072;
	localparam logic signed [47:0] ENV_MAX    = 48'sd67108864;
	localparam logic signed [17:0] OUT_MAX    = 18'sd32767;
	localparam logic signed [17:0] OUT_MIN    = -18'sd32768;

	// quotient is below 2^18, so the divider runs one step per quotient bit
	localparam int DivSteps = 18;
	localparam int DivCntW  = $clog2(DivSteps + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAIN_MUL,
		ST_GAIN_ADJ,
		ST_ENV_DIFF,
		ST_ENV_MUL,
		ST_ENV_UPD,
		ST_LIM_CHK,
		ST_LIM_MUL,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [29:0] a;
		logic signed [18:0] b;
	} mul_op_t;

	typedef struct packed {
		logic        start;
		logic [47:0] dividend;
		logic [29:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic [17:0] quotient;
	} div_stat_t;

endpackage

/* design/mgpl_mul.sv */
// shared signed multiplier with registered product
// depends on mgpl_pkg
`timescale 1ns / 1ps

module mgpl_mul (
	input  logic                clk,
	input  mgpl_pkg::mul_op_t   op,
	output logic signed [47:0]  prod_q
);

	logic signed [47:0] a_ext;
	logic signed [47:0] b_ext;

	assign a_ext = {{18{op.a[29]}}, op.a};
	assign b_ext = {{29{op.b[18]}}, op.b};

	always_ff @(posedge clk) begin
		prod_q <= a_ext * b_ext;
	end

endmodule

/* design/mgpl_div.sv */
// restoring divider, one quotient bit per cycle
// depends on mgpl_pkg
`timescale 1ns / 1ps

module mgpl_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mgpl_pkg::div_req_t    req,
	output mgpl_pkg::div_stat_t   stat
);

	logic [29:0]                   rem_q;
	logic [17:0]                   low_q;
	logic [29:0]                   den_q;
	logic [mgpl_pkg::DivCntW-1:0]  cnt_q;
	logic                          busy_q;
	logic [30:0]                   trial;
	logic [30:0]                   diff;
	logic                          fits;

	assign trial = {rem_q, low_q[17]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= mgpl_pkg::DivCntW'(mgpl_pkg::DivSteps);
		end else if (busy_q) begin
			cnt_q <= cnt_q - mgpl_pkg::DivCntW'(1);
			if (cnt_q == mgpl_pkg::DivCntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[47:18];
			low_q <= req.dividend[17:0];
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[29:0] : trial[29:0];
			low_q <= {low_q[16:0], fits};
		end
	end

	assign stat.busy     = busy_q;
	assign stat.quotient = low_q;

endmodule

/* design/master_gain_peak_limiter.sv */
// top level: config registers, sequencer, envelope datapath and output register
// depends on mgpl_pkg, mgpl_mul, mgpl_div
`timescale 1ns / 1ps

// Master gain, shared-envelope peak limiter, output clamp and per-run peak meter.
// One sample is taken per transfer and the block stalls its input until the
// result sits in the output register. With the limiter off a sample takes the
// gain states only; with the limiter on it also updates the envelope, and when
// the envelope is above the threshold the 18-step restoring divider forms the
// limited magnitude, which makes that the longest path. All products go through
// one shared 30x19 multiplier. A stalled output register holds the block in its
// finish state until the output register is free.
module master_gain_peak_limiter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [17:0]                 sample_in,
	input  logic                               chan_in,
	input  logic                               last_of_run,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [15:0]                 sample_out,
	output logic                               chan_out,
	output logic [15:0]                        run_peak,
	output logic                               peak_valid,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mgpl_pkg::CfgIndexW-1:0]     cfg_index,
	input  logic [mgpl_pkg::CfgDataW-1:0]      cfg_data
);

	mgpl_pkg::state_t    state_q;
	mgpl_pkg::state_t    state_nxt;
	mgpl_pkg::mul_op_t   mul_op;
	mgpl_pkg::div_req_t  div_req;
	mgpl_pkg::div_stat_t div_stat;
	logic signed [47:0]  prod_q;

	logic [15:0] master_gain_q;
	logic        limiter_on_q;
	logic [14:0] limit_threshold_q;
	logic [15:0] attack_coef_q;
	logic [15:0] release_coef_q;

	logic [26:0] env_q;
	logic [15:0] peak_q;

	logic signed [17:0] x_q;
	logic               chan_q;
	logic               last_q;
	logic signed [17:0] y_q;
	logic [17:0]        mag_q;
	logic signed [27:0] diff_q;
	logic [15:0]        rate_q;
	logic [28:0]        num_q;
	logic [29:0]        den_q;
	logic               lim_act_q;

	logic [15:0]        gain_eff;
	logic signed [47:0] gain_sum;
	logic signed [47:0] gain_sh;
	logic signed [17:0] y_gain;
	logic [26:0]        target;
	logic signed [47:0] env_sum;
	logic [23:0]        t24;
	logic               out_free;
	logic               out_load;
	logic signed [17:0] y_out;
	logic [15:0]        omag;
	logic [15:0]        peak_nxt;
	logic [17:0]        quo;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != mgpl_pkg::ST_IDLE);
	assign out_free  = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_gain_q     <= mgpl_pkg::MASTER_GAIN_RST;
			limiter_on_q      <= mgpl_pkg::LIMITER_ON_RST;
			limit_threshold_q <= mgpl_pkg::LIMIT_THRESHOLD_RST;
			attack_coef_q     <= mgpl_pkg::ATTACK_COEF_RST;
			release_coef_q    <= mgpl_pkg::RELEASE_COEF_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mgpl_pkg::REG_MASTER_GAIN:     master_gain_q     <= cfg_data;
				mgpl_pkg::REG_LIMITER_ON:      limiter_on_q      <= cfg_data[0];
				mgpl_pkg::REG_LIMIT_THRESHOLD: limit_threshold_q <= cfg_data[14:0];
				mgpl_pkg::REG_ATTACK_COEF:     attack_coef_q     <= cfg_data;
				mgpl_pkg::REG_RELEASE_COEF:    release_coef_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	mgpl_mul u_mul (
		.clk    (clk),
		.op     (mul_op),
		.prod_q (prod_q)
	);

	mgpl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mgpl_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = mgpl_pkg::ST_GAIN_MUL;
				end
			end
			mgpl_pkg::ST_GAIN_MUL: state_nxt = mgpl_pkg::ST_GAIN_ADJ;
			mgpl_pkg::ST_GAIN_ADJ: begin
				state_nxt = limiter_on_q ? mgpl_pkg::ST_ENV_DIFF : mgpl_pkg::ST_FINISH;
			end
			mgpl_pkg::ST_ENV_DIFF: state_nxt = mgpl_pkg::ST_ENV_MUL;
			mgpl_pkg::ST_ENV_MUL:  state_nxt = mgpl_pkg::ST_ENV_UPD;
			mgpl_pkg::ST_ENV_UPD:  state_nxt = mgpl_pkg::ST_LIM_CHK;
			mgpl_pkg::ST_LIM_CHK: begin
				state_nxt = lim_act_q ? mgpl_pkg::ST_LIM_MUL : mgpl_pkg::ST_FINISH;
			end
			mgpl_pkg::ST_LIM_MUL:  state_nxt = mgpl_pkg::ST_DIV_LOAD;
			mgpl_pkg::ST_DIV_LOAD: state_nxt = mgpl_pkg::ST_DIV_RUN;
			mgpl_pkg::ST_DIV_RUN: begin
				if (!div_stat.busy) begin
					state_nxt = mgpl_pkg::ST_FINISH;
				end
			end
			mgpl_pkg::ST_FINISH: begin
				if (out_free) begin
					state_nxt = mgpl_pkg::ST_IDLE;
				end
			end
			default: state_nxt = mgpl_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mul_op           = '0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = den_q;
		out_load         = 1'b0;
		case (state_q)
			mgpl_pkg::ST_GAIN_MUL: begin
				mul_op.a = {{12{x_q[17]}}, x_q};
				mul_op.b = $signed({3'b000, gain_eff});
			end
			mgpl_pkg::ST_ENV_MUL: begin
				mul_op.a = {{2{diff_q[27]}}, diff_q};
				mul_op.b = $signed({3'b000, rate_q});
			end
			mgpl_pkg::ST_LIM_MUL: begin
				mul_op.a = $signed({1'b0, num_q});
				mul_op.b = $signed({1'b0, mag_q});
			end
			mgpl_pkg::ST_DIV_LOAD: div_req.start = 1'b1;
			mgpl_pkg::ST_FINISH:   out_load      = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mgpl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign gain_eff = (master_gain_q > mgpl_pkg::GAIN_MAX) ? mgpl_pkg::GAIN_MAX : master_gain_q;
	assign gain_sum = prod_q + mgpl_pkg::GAIN_ROUND;
	assign gain_sh  = gain_sum >>> 14;

	always_comb begin
		if (gain_sh > mgpl_pkg::SAMPLE_MAX) begin
			y_gain = mgpl_pkg::SAMPLE_MAX[17:0];
		end else if (gain_sh < mgpl_pkg::SAMPLE_MIN) begin
			y_gain = mgpl_pkg::SAMPLE_MIN[17:0];
		end else begin
			y_gain = gain_sh[17:0];
		end
	end

	assign target  = (mag_q > {3'b000, limit_threshold_q}) ? {mag_q, 9'b0} : 27'd0;
	assign env_sum = $signed({21'b0, env_q}) + (prod_q >>> 16);
	assign t24     = {limit_threshold_q, 9'b0};
	assign quo     = div_stat.quotient;

	always_comb begin
		if (y_q > mgpl_pkg::OUT_MAX) begin
			y_out = mgpl_pkg::OUT_MAX;
		end else if (y_q < mgpl_pkg::OUT_MIN) begin
			y_out = mgpl_pkg::OUT_MIN;
		end else begin
			y_out = y_q;
		end
	end

	assign omag     = y_out[17] ? 16'(-y_out) : y_out[15:0];
	assign peak_nxt = (omag > peak_q) ? omag : peak_q;

	// sample datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mgpl_pkg::ST_IDLE: begin
				x_q    <= sample_in;
				chan_q <= chan_in;
				last_q <= last_of_run;
			end
			mgpl_pkg::ST_GAIN_ADJ: begin
				y_q   <= y_gain;
				mag_q <= y_gain[17] ? 18'(-y_gain) : y_gain;
			end
			mgpl_pkg::ST_ENV_DIFF: begin
				diff_q <= $signed({1'b0, target}) - $signed({1'b0, env_q});
				rate_q <= (target > env_q) ? attack_coef_q : release_coef_q;
			end
			mgpl_pkg::ST_ENV_UPD: begin
				lim_act_q <= (env_sum > $signed({24'b0, t24}));
			end
			mgpl_pkg::ST_LIM_CHK: begin
				num_q <= 29'({t24, 3'b000}) + 29'(t24) + 29'(env_q);
				den_q <= 30'({env_q, 3'b000}) + 30'({env_q, 1'b0});
			end
			mgpl_pkg::ST_DIV_RUN: begin
				if (!div_stat.busy) begin
					y_q <= y_q[17] ? -$signed(quo) : $signed(quo);
				end
			end
			default: ;
		endcase
	end

	// envelope, peak and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q      <= '0;
			peak_q     <= '0;
			out_valid  <= 1'b0;
			sample_out <= '0;
			chan_out   <= 1'b0;
			run_peak   <= '0;
			peak_valid <= 1'b0;
		end else begin
			if (state_q == mgpl_pkg::ST_ENV_UPD) begin
				if (env_sum < 48'sd0) begin
					env_q <= '0;
				end else if (env_sum > mgpl_pkg::ENV_MAX) begin
					env_q <= mgpl_pkg::ENV_MAX[26:0];
				end else begin
					env_q <= env_sum[26:0];
				end
			end
			if (out_load) begin
				out_valid  <= 1'b1;
				sample_out <= y_out[15:0];
				chan_out   <= chan_q;
				if (last_q) begin
					run_peak   <= peak_nxt;
					peak_valid <= 1'b1;
					peak_q     <= '0;
				end else begin
					run_peak   <= '0;
					peak_valid <= 1'b0;
					peak_q     <= peak_nxt;
				end
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

/* design/mgpl_chk.sv */
// port-level checker for the master gain peak limiter, bound to the top level
// depends on master_gain_peak_limiter
`timescale 1ns / 1ps

module mgpl_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic signed [15:0]             sample_out,
	input logic [15:0]                    run_peak,
	input logic                           peak_valid
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(run_peak))
		else $error("output changed while stalled");

	// no peak reported outside a run end
	a_peak_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!peak_valid |-> run_peak == 16'd0)
		else $error("run_peak nonzero without peak_valid");

	// input is held off while a sample is in work
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// a fresh result only follows a busy period
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	// reported peak never exceeds full scale
	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		peak_valid |-> run_peak <= 16'd32768)
		else $error("run_peak out of range");

endmodule

bind master_gain_peak_limiter mgpl_chk u_mgpl_chk (.*);
